/* rtl/tgbp_pkg.sv */
`default_nettype none
package tgbp_pkg;

    localparam int NUM_TABLES_DEF       = 4;
    localparam int TABLE_INDEX_BITS_DEF = 10;
    localparam int TAG_BITS_DEF         = 9;
    localparam int MAX_HISTORY_DEF      = 64;
    localparam int BASE_INDEX_BITS_DEF  = 12;

    localparam int PC_BITS     = 48;
    localparam int CTR_BITS    = 3;
    localparam int USE_BITS    = 2;
    localparam int BASE_BITS   = 2;
    localparam int LFSR_BITS   = 16;
    localparam int PERIOD_BITS = 20;
    localparam int THR_BITS    = 4;
    localparam int ABC_BITS    = 4;
    localparam int CFG_BITS    = 20;
    localparam int CFG_IDX_BITS = 2;

    localparam logic [LFSR_BITS-1:0]   LFSR_TAPS     = 16'hB400;
    localparam logic [LFSR_BITS-1:0]   LFSR_SEED_RST = 16'd44257;
    localparam logic [PERIOD_BITS-1:0] PERIOD_RST    = 20'd262144;
    localparam logic [THR_BITS-1:0]    THR_RST       = 4'd8;
    localparam logic [CTR_BITS-1:0]    CTR_ALLOC     = 3'd4;
    localparam logic [CTR_BITS-1:0]    CTR_WEAK_NT   = 3'd3;
    localparam logic [CTR_BITS-1:0]    CTR_MAX       = 3'd7;
    localparam logic [USE_BITS-1:0]    USE_MAX       = 2'd3;
    localparam logic [BASE_BITS-1:0]   BASE_RST      = 2'd1;
    localparam logic [BASE_BITS-1:0]   BASE_MAX      = 2'd3;
    localparam logic [ABC_BITS-1:0]    ABC_MAX       = 4'd15;
    localparam int MAX_PROVIDER = NUM_TABLES_DEF;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_RESET_PERIOD = 2'd0,
        CFG_ALT_THRESHOLD = 2'd1,
        CFG_LFSR_SEED = 2'd2,
        CFG_UNUSED = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic en;
        logic taken;
    } t_hist_upd;

    function automatic int hist_len(int t, int n, int mh);
        int s;
        int v;
        s = n - 1 - t;
        v = (s < 32) ? (mh >>> s) : 0;
        return (v != 0) ? v : 1;
    endfunction

endpackage
`default_nettype wire

/* rtl/tagged_geometric_branch_predictor_top.sv */
`default_nettype none
// Branch predictor with tagged tables of geometric history lengths and a bimodal base.
// Slave channel: one request per resolved conditional branch, tdata carries the pc in
// bits 47:0 and the taken flag in bit 48. Master channel: one result per request,
// tdata carries the prediction in bit 0, the provider table in bits 3:1 and the
// mispredict flag in bit 4.
// For each request every table is read, then one compare unit walks the tables from
// the longest history down one table a cycle until the provider and alternate are
// found or the shortest table has been compared; the update state then writes the
// updates and the done state hands the result to the output register. The next
// request is accepted in the cycle after that.
// When the useful-counter aging period expires, a sweep rewrites every table entry
// before the next request is taken.
// After reset a clearing pass initializes all tables; requests are not accepted
// meanwhile, configuration writes are.
// The output register lets the next request start while a result waits; if the
// receiver stalls, that next request finishes its update and holds until the
// output register frees up.
module tagged_geometric_branch_predictor_top
    import tgbp_pkg::*;
#(
    parameter int NUM_TABLES       = NUM_TABLES_DEF,
    parameter int TABLE_INDEX_BITS = TABLE_INDEX_BITS_DEF,
    parameter int TAG_BITS         = TAG_BITS_DEF,
    parameter int MAX_HISTORY      = MAX_HISTORY_DEF,
    parameter int BASE_INDEX_BITS  = BASE_INDEX_BITS_DEF
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_s_tvalid,
    output logic                    o_s_tready,
    input  wire [55:0]              i_s_tdata,   // branch_pc, outcome_taken
    output logic                    o_m_tvalid,
    input  wire                     i_m_tready,
    output logic [7:0]              o_m_tdata,   // predicted_taken, provider_index, was_mispredicted
    input  wire                     i_cfg_we,
    input  wire [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  wire [CFG_BITS-1:0]      i_cfg_data
);
    localparam int N    = NUM_TABLES;
    localparam int TIB  = TABLE_INDEX_BITS;
    localparam int TGB  = TAG_BITS;
    localparam int BIB  = BASE_INDEX_BITS;
    localparam int EW   = CTR_BITS + TGB + USE_BITS;
    localparam int SCW  = (N > 1) ? $clog2(N) : 1;
    localparam int PW   = $clog2(N + 1);
    localparam int IB   = (TIB > BIB) ? TIB : BIB;
    localparam int TSIZE = 1 << TIB;

    typedef enum logic [5:0] {
        S_INIT = 6'b000001,
        S_IDLE = 6'b000010,
        S_SCAN = 6'b000100,
        S_UPD  = 6'b001000,
        S_DONE = 6'b010000,
        S_CLR  = 6'b100000
    } t_state;

    t_state r_state, n_state;

    logic [PERIOD_BITS-1:0] r_rper;
    logic [THR_BITS-1:0]    r_thr;
    logic [LFSR_BITS-1:0]   r_lfsr, n_lfsr;
    logic [ABC_BITS-1:0]    r_abc, n_abc;
    logic [PERIOD_BITS-1:0] r_pcnt, n_pcnt;
    logic                   r_phase;
    logic [USE_BITS-1:0]    r_keep;
    logic                   r_clr_pend, n_clr_pend;
    logic [IB-1:0]          r_init;
    logic [TIB:0]           r_sw;

    logic                   r_taken;
    logic [BIB-1:0]         r_bidx;
    logic [N-1:0][TIB-1:0]  r_idx;
    logic [N-1:0][TGB-1:0]  r_tag;
    logic [N-1:0][TIB-1:0]  w_idx;
    logic [N-1:0][TGB-1:0]  w_tag;

    logic [SCW-1:0]         r_scan;
    logic                   r_found;
    logic [PW-1:0]          r_prov;
    logic [SCW-1:0]         r_prov_t;
    logic                   r_alt_ok;
    logic [CTR_BITS-1:0]    r_prov_ctr, r_alt_ctr;
    logic [USE_BITS-1:0]    r_prov_u;

    logic                   r_res_pred, r_res_misp;
    logic [PW-1:0]          r_res_prov;

    logic [N-1:0][EW-1:0]   w_rd, w_wd;
    logic [N-1:0]           w_we, w_re;
    logic [N-1:0][TIB-1:0]  w_waddr, w_raddr;
    logic [BASE_BITS-1:0]   w_brd, w_bwd;
    logic                   w_bwe;
    logic [BIB-1:0]         w_bwaddr;

    logic                   w_accept;
    logic                   w_out_free;
    t_hist_upd              w_hupd;
    logic                   w_hit;

    logic                   w_pred, w_misp, w_alt_right, w_prov_right, w_fresh, w_ppred, w_apred;
    logic [USE_BITS-1:0]    w_prov_u_n;
    logic [CTR_BITS-1:0]    w_prov_ctr_n;
    logic                   w_alloc, w_decay;
    logic [SCW-1:0]         w_pick;
    logic [LFSR_BITS-1:0]   w_lfsr_st;
    logic [PERIOD_BITS-1:0] w_pcnt_inc;

    assign o_s_tready = (r_state == S_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_out_free = !o_m_tvalid || i_m_tready;

    assign w_hupd = t_hist_upd'{en: (r_state == S_UPD), taken: r_taken};

    tgbp_hist #(
        .NUM_TABLES(N), .TABLE_INDEX_BITS(TIB), .TAG_BITS(TGB), .MAX_HISTORY(MAX_HISTORY)
    ) u_hist (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_upd(w_hupd),
        .i_pc(i_s_tdata[PC_BITS-1:0]), .o_idx(w_idx), .o_tag(w_tag)
    );

    for (genvar t = 0; t < N; t++) begin : g_ram
        tgbp_ram #(.WIDTH(EW), .DEPTH(TSIZE)) u_ram (
            .i_clk(i_clk), .i_we(w_we[t]), .i_waddr(w_waddr[t]), .i_wdata(w_wd[t]),
            .i_re(w_re[t]), .i_raddr(w_raddr[t]), .o_rdata(w_rd[t])
        );
    end

    tgbp_ram #(.WIDTH(BASE_BITS), .DEPTH(1 << BIB)) u_base (
        .i_clk(i_clk), .i_we(w_bwe), .i_waddr(w_bwaddr), .i_wdata(w_bwd),
        .i_re(w_accept), .i_raddr(i_s_tdata[BIB-1:0]), .o_rdata(w_brd)
    );

    assign w_hit = (w_rd[r_scan][TGB+1:2] == r_tag[r_scan]);

    assign w_ppred = r_prov_ctr[CTR_BITS-1];
    assign w_apred = r_alt_ctr[CTR_BITS-1];
    assign w_fresh = (r_prov_u == '0) && ((r_prov_ctr == CTR_WEAK_NT) ||
                     (r_prov_ctr == CTR_ALLOC)) && (r_abc >= r_thr);
    assign w_pred  = !r_found ? w_brd[1] : ((w_fresh && r_alt_ok) ? w_apred : w_ppred);
    assign w_misp  = (w_pred != r_taken);
    assign w_alt_right  = r_alt_ok && (w_apred == r_taken) && (w_ppred != r_taken);
    assign w_prov_right = r_alt_ok && (w_apred != r_taken) && (w_ppred == r_taken);
    assign w_lfsr_st = (r_lfsr >> 1) ^ (r_lfsr[0] ? LFSR_TAPS : '0);
    assign w_pcnt_inc = r_pcnt + 1'b1;

    always_comb begin
        w_prov_u_n = r_prov_u;
        if (w_alt_right && r_prov_u != '0) begin
            w_prov_u_n = r_prov_u - 1'b1;
        end else if (w_prov_right && r_prov_u != USE_MAX) begin
            w_prov_u_n = r_prov_u + 1'b1;
        end
        w_prov_ctr_n = r_prov_ctr;
        if (r_taken && r_prov_ctr != CTR_MAX) begin
            w_prov_ctr_n = r_prov_ctr + 1'b1;
        end else if (!r_taken && r_prov_ctr != '0) begin
            w_prov_ctr_n = r_prov_ctr - 1'b1;
        end
    end

    always_comb begin
        logic [PW-1:0] cnt;
        logic          picked;
        cnt    = '0;
        picked = 1'b0;
        w_pick = '0;
        for (int t = 0; t < N; t++) begin
            if (PW'(t) >= r_prov && w_rd[t][USE_BITS-1:0] == '0) begin
                if (cnt == '0) begin
                    w_pick = SCW'(t);
                end
                if (!picked && w_lfsr_st[4'(cnt)]) begin
                    w_pick = SCW'(t);
                    picked = 1'b1;
                end
                cnt = cnt + 1'b1;
            end
        end
        w_alloc = w_misp && (cnt != '0);
        w_decay = w_misp && (cnt == '0);
    end

    always_comb begin
        for (int t = 0; t < N; t++) begin
            w_re[t]    = 1'b0;
            w_raddr[t] = w_idx[t];
            w_we[t]    = 1'b0;
            w_waddr[t] = r_idx[t];
            w_wd[t]    = w_rd[t];
            unique case (r_state)
                S_INIT: begin
                    w_we[t]    = ((r_init >> TIB) == '0);
                    w_waddr[t] = r_init[TIB-1:0];
                    w_wd[t]    = '0;
                end
                S_IDLE: begin
                    w_re[t] = w_accept;
                end
                S_UPD: begin
                    if (r_found && SCW'(t) == r_prov_t) begin
                        w_we[t] = 1'b1;
                        w_wd[t] = {w_prov_ctr_n, w_rd[t][TGB+1:2], w_prov_u_n};
                    end else if (w_alloc && SCW'(t) == w_pick) begin
                        w_we[t] = 1'b1;
                        w_wd[t] = {CTR_ALLOC, r_tag[t], w_rd[t][USE_BITS-1:0]};
                    end else if (w_decay && PW'(t) >= r_prov &&
                                 w_rd[t][USE_BITS-1:0] != '0) begin
                        w_we[t] = 1'b1;
                        w_wd[t] = {w_rd[t][EW-1:USE_BITS], w_rd[t][USE_BITS-1:0] - 1'b1};
                    end
                end
                S_CLR: begin
                    w_re[t]    = !r_sw[TIB];
                    w_raddr[t] = r_sw[TIB-1:0];
                    w_we[t]    = (r_sw != '0);
                    w_waddr[t] = TIB'(r_sw - 1'b1);
                    w_wd[t]    = {w_rd[t][EW-1:USE_BITS], w_rd[t][USE_BITS-1:0] & r_keep};
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        w_bwe    = 1'b0;
        w_bwaddr = r_bidx;
        w_bwd    = w_brd;
        if (r_state == S_INIT) begin
            w_bwe    = ((r_init >> BIB) == '0);
            w_bwaddr = r_init[BIB-1:0];
            w_bwd    = BASE_RST;
        end else if (r_state == S_UPD && !r_found) begin
            if (r_taken && w_brd != BASE_MAX) begin
                w_bwe = 1'b1;
                w_bwd = w_brd + 1'b1;
            end else if (!r_taken && w_brd != '0) begin
                w_bwe = 1'b1;
                w_bwd = w_brd - 1'b1;
            end
        end
    end

    always_comb begin
        n_state    = r_state;
        n_abc      = r_abc;
        n_lfsr     = r_lfsr;
        n_pcnt     = r_pcnt;
        n_clr_pend = r_clr_pend;
        unique case (r_state)
            S_INIT: if (r_init == '1) n_state = S_IDLE;
            S_IDLE: if (w_accept) n_state = S_SCAN;
            S_SCAN: if (r_scan == '0 || (w_hit && r_found)) n_state = S_UPD;
            S_UPD: begin
                n_state = S_DONE;
                if (r_found) begin
                    if (w_alt_right && r_abc != ABC_MAX) begin
                        n_abc = r_abc + 1'b1;
                    end else if (w_prov_right && r_abc != '0) begin
                        n_abc = r_abc - 1'b1;
                    end
                end
                if (w_alloc) n_lfsr = w_lfsr_st;
                n_pcnt = w_pcnt_inc;
                if (w_pcnt_inc >= r_rper) begin
                    n_pcnt     = '0;
                    n_clr_pend = 1'b1;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state    = r_clr_pend ? S_CLR : S_IDLE;
                    n_clr_pend = 1'b0;
                end
            end
            S_CLR: if (r_sw == (TIB+1)'(TSIZE)) n_state = S_IDLE;
            default: n_state = S_INIT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_INIT;
            r_init     <= '0;
            r_sw       <= '0;
            r_rper     <= PERIOD_RST;
            r_thr      <= THR_RST;
            r_lfsr     <= LFSR_SEED_RST;
            r_abc      <= '0;
            r_pcnt     <= '0;
            r_phase    <= 1'b0;
            r_clr_pend <= 1'b0;
            o_m_tvalid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_abc      <= n_abc;
            r_lfsr     <= n_lfsr;
            r_pcnt     <= n_pcnt;
            r_clr_pend <= n_clr_pend;
            if (r_state == S_INIT) r_init <= r_init + 1'b1;
            if (r_state == S_CLR) begin
                r_sw <= r_sw + 1'b1;
            end else begin
                r_sw <= '0;
            end
            if (r_state == S_UPD && n_clr_pend) begin
                r_phase <= !r_phase;
            end
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    CFG_RESET_PERIOD:  r_rper <= i_cfg_data;
                    CFG_ALT_THRESHOLD: r_thr  <= i_cfg_data[THR_BITS-1:0];
                    CFG_LFSR_SEED: begin
                        r_lfsr <= (i_cfg_data[LFSR_BITS-1:0] != '0) ?
                                  i_cfg_data[LFSR_BITS-1:0] : LFSR_BITS'(1);
                    end
                    CFG_UNUSED: begin
                    end
                endcase
            end
            if (r_state == S_DONE && w_out_free) begin
                o_m_tvalid <= 1'b1;
            end else if (i_m_tready) begin
                o_m_tvalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_taken <= i_s_tdata[PC_BITS];
            r_bidx  <= i_s_tdata[BIB-1:0];
            r_idx   <= w_idx;
            r_tag   <= w_tag;
            r_scan  <= SCW'(N - 1);
            r_found <= 1'b0;
            r_alt_ok <= 1'b0;
            r_prov  <= '0;
            r_prov_t <= '0;
        end else if (r_state == S_SCAN) begin
            if (r_scan != '0) r_scan <= r_scan - 1'b1;
            if (w_hit) begin
                if (!r_found) begin
                    r_found    <= 1'b1;
                    r_prov     <= PW'(r_scan) + 1'b1;
                    r_prov_t   <= r_scan;
                    r_prov_ctr <= w_rd[r_scan][EW-1:EW-CTR_BITS];
                    r_prov_u   <= w_rd[r_scan][USE_BITS-1:0];
                end else begin
                    r_alt_ok  <= 1'b1;
                    r_alt_ctr <= w_rd[r_scan][EW-1:EW-CTR_BITS];
                end
            end
        end
        if (r_state == S_UPD) begin
            r_res_pred <= w_pred;
            r_res_misp <= w_misp;
            r_res_prov <= r_prov;
            r_keep     <= {r_phase, !r_phase};
        end
        if (r_state == S_DONE && w_out_free) begin
            o_m_tdata <= {3'b000, r_res_misp, 3'(r_res_prov), r_res_pred};
        end
    end
endmodule
`default_nettype wire

/* rtl/tgbp_ram.sv */
`default_nettype none
module tgbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire                     i_clk,
    input  wire                     i_we,
    input  wire [$clog2(DEPTH)-1:0] i_waddr,
    input  wire [WIDTH-1:0]         i_wdata,
    input  wire                     i_re,
    input  wire [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]        o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

/* rtl/tgbp_hist.sv */
`default_nettype none
module tgbp_hist
    import tgbp_pkg::*;
#(
    parameter int NUM_TABLES       = NUM_TABLES_DEF,
    parameter int TABLE_INDEX_BITS = TABLE_INDEX_BITS_DEF,
    parameter int TAG_BITS         = TAG_BITS_DEF,
    parameter int MAX_HISTORY      = MAX_HISTORY_DEF
) (
    input  wire                                          i_clk,
    input  wire                                          i_rst_n,
    input  t_hist_upd                                    i_upd,
    input  wire [PC_BITS-1:0]                            i_pc,
    output logic [NUM_TABLES-1:0][TABLE_INDEX_BITS-1:0]  o_idx,
    output logic [NUM_TABLES-1:0][TAG_BITS-1:0]          o_tag
);
    localparam int TIB = TABLE_INDEX_BITS;
    localparam int TGB = TAG_BITS;

    logic [MAX_HISTORY-1:0] r_hist;
    logic [MAX_HISTORY-1:0] n_hist;

    assign n_hist = {r_hist[MAX_HISTORY-2:0], i_upd.taken};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist <= '0;
        end else if (i_upd.en) begin
            r_hist <= n_hist;
        end
    end

    for (genvar t = 0; t < NUM_TABLES; t++) begin : g_tab
        localparam int LEN = hist_len(t, NUM_TABLES, MAX_HISTORY);
        localparam int SI  = LEN % TABLE_INDEX_BITS;
        localparam int SA  = LEN % TAG_BITS;
        localparam int SB  = LEN % (TAG_BITS - 1);

        logic [TIB-1:0] r_fi, n_fi;
        logic [TGB-1:0] r_fa, n_fa;
        logic [TGB-2:0] r_fb, n_fb;
        logic           w_out;

        assign w_out = r_hist[LEN-1];

        always_comb begin
            n_fi = {r_fi[TIB-2:0], i_upd.taken};
            n_fi[0] = n_fi[0] ^ r_fi[TIB-1];
            n_fi[SI] = n_fi[SI] ^ w_out;
            n_fa = {r_fa[TGB-2:0], i_upd.taken};
            n_fa[0] = n_fa[0] ^ r_fa[TGB-1];
            n_fa[SA] = n_fa[SA] ^ w_out;
            n_fb = {r_fb[TGB-3:0], i_upd.taken};
            n_fb[0] = n_fb[0] ^ r_fb[TGB-2];
            n_fb[SB] = n_fb[SB] ^ w_out;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_fi <= '0;
                r_fa <= '0;
                r_fb <= '0;
            end else if (i_upd.en) begin
                r_fi <= n_fi;
                r_fa <= n_fa;
                r_fb <= n_fb;
            end
        end

        assign o_idx[t] = i_pc[TIB-1:0] ^ r_fi;
        assign o_tag[t] = i_pc[TGB+1:2] ^ r_fa ^ {r_fb, 1'b0};
    end
endmodule
`default_nettype wire

/* rtl/tgbp_checker.sv */
`default_nettype none
module tgbp_checker
    import tgbp_pkg::*;
(
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_s_tvalid,
    input wire        o_s_tready,
    input wire        o_m_tvalid,
    input wire        i_m_tready,
    input wire [7:0]  o_m_tdata
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("result dropped while stalled");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("request taken while busy");

    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid && !o_s_tready)
        else $error("reset did not clear handshake");

    a_prov: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[3:1] <= 3'(MAX_PROVIDER))
        else $error("provider out of range");
endmodule

bind tagged_geometric_branch_predictor_top tgbp_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_s_tvalid(i_s_tvalid), .o_s_tready(o_s_tready),
    .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready), .o_m_tdata(o_m_tdata)
);
`default_nettype wire
